### sv/hkbd_pkg.sv
// hkbd_pkg: shared types, constants and the US keymap for the scan assembler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package hkbd_pkg;

  localparam int SLOTS        = 6;
  localparam int SLOT_W       = 3;
  localparam int REPORT_BYTES = 8;
  localparam int OUT_LIMIT    = 34;
  localparam int COUNT_W      = 6;

  localparam logic [7:0] SHIFT_MASK   = 8'h02 | 8'h20;
  localparam logic [7:0] KC_ENTER     = 8'h28;
  localparam logic [7:0] KC_BACKSPACE = 8'h2a;

  // input transaction: one keyboard report or a disconnect event
  typedef struct packed {
    logic       mode;
    logic [6:0] report_length;
    logic [7:0] modifiers;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } hkbd_in_t;

  // output transaction: one character of a completed scan
  typedef struct packed {
    logic [6:0] scan_char;
    logic       scan_last;
  } hkbd_out_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_ENTER,
    KIND_BKSP
  } key_kind_t;

  // what one lane found for its key slot
  typedef struct packed {
    key_kind_t  kind;
    logic [6:0] ch;
  } lane_info_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } seq_state_t;

  // US keymap, returns 0 for unmapped codes
  function automatic logic [6:0] us_char(input logic [6:0] code, input logic shift);
    logic [13:0] pair;
    logic [6:0]  ofs;
    begin
      pair = 14'h0;
      ofs  = code - 7'h04;
      if (code >= 7'h04 && code <= 7'h1d) begin
        pair = {7'h61 + ofs, 7'h41 + ofs};
      end else begin
        unique case (code)
          7'h1e:   pair = {7'h31, 7'h21};
          7'h1f:   pair = {7'h32, 7'h40};
          7'h20:   pair = {7'h33, 7'h23};
          7'h21:   pair = {7'h34, 7'h24};
          7'h22:   pair = {7'h35, 7'h25};
          7'h23:   pair = {7'h36, 7'h5e};
          7'h24:   pair = {7'h37, 7'h26};
          7'h25:   pair = {7'h38, 7'h2a};
          7'h26:   pair = {7'h39, 7'h28};
          7'h27:   pair = {7'h30, 7'h29};
          7'h2b:   pair = {7'h09, 7'h09};
          7'h2c:   pair = {7'h20, 7'h20};
          7'h2d:   pair = {7'h2d, 7'h5f};
          7'h2e:   pair = {7'h3d, 7'h2b};
          7'h2f:   pair = {7'h5b, 7'h7b};
          7'h30:   pair = {7'h5d, 7'h7d};
          7'h31:   pair = {7'h5c, 7'h7c};
          7'h32:   pair = {7'h23, 7'h7e};
          7'h33:   pair = {7'h3b, 7'h3a};
          7'h34:   pair = {7'h27, 7'h22};
          7'h35:   pair = {7'h60, 7'h7e};
          7'h36:   pair = {7'h2c, 7'h3c};
          7'h37:   pair = {7'h2e, 7'h3e};
          7'h38:   pair = {7'h2f, 7'h3f};
          default: pair = 14'h0;
        endcase
      end
      us_char = shift ? pair[6:0] : pair[13:7];
    end
  endfunction

endpackage

`default_nettype wire

### sv/hkbd_lane.sv
// hkbd_lane: classifies one key slot of a report (new press, kind, mapped char)
// depends on hkbd_pkg for lane_info_t and the keymap function
`timescale 1ns / 1ps
`default_nettype none

module hkbd_lane
  import hkbd_pkg::*;
(
  input  wire logic [7:0]            key,
  input  wire logic                  shift,
  input  wire logic [SLOTS-1:0][7:0] held,
  output lane_info_t                 info
);

  logic       seen;
  logic [6:0] ch;

  // a slot is a press only if its code was absent from the previous report
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (held[i] == key) seen = 1'b1;
    end
  end

  assign ch = us_char(key[6:0], shift);

  // classify the press
  always_comb begin
    info.ch   = ch;
    info.kind = KIND_NONE;
    if (key != 8'h00 && !seen) begin
      if (key == KC_ENTER) begin
        info.kind = KIND_ENTER;
      end else if (key == KC_BACKSPACE) begin
        info.kind = KIND_BKSP;
      end else if (!key[7] && ch != 7'h00) begin
        info.kind = KIND_CHAR;
      end
    end
  end

endmodule

`default_nettype wire

### sv/hkbd_text_buf.sv
// hkbd_text_buf: character buffer, one write port and one registered read port
// imports hkbd_pkg like the other modules; instantiated by the top level
`timescale 1ns / 1ps
`default_nettype none

module hkbd_text_buf
  import hkbd_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [6:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [6:0]             rd_data
);

  logic [6:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### sv/hid_keyboard_scan_assembler.sv
// hid_keyboard_scan_assembler: top level, six slot lanes, in-order merge sequencer
// depends on hkbd_pkg, hkbd_lane and hkbd_text_buf
//
//   channel | direction | handshake                  | payload
//   report  | in        | report_valid/report_ready  | hkbd_in_t  (one report or disconnect)
//   scan    | out       | scan_valid/scan_ready      | hkbd_out_t (one scan character)
//
// A report is accepted in the idle state, then each key slot is applied in slot order (6),
// and each Enter that emits adds an emit step that issues one buffered character per cycle
// while the scan channel does not stall.
// The sequencer works on one report at a time; report_ready is high only when it is idle.
// Disconnects and short reports complete in the accept cycle.
// Characters leave through a buffer read stage and an output register, so a stalled
// scan channel holds the sequencer in its emit step. Reset is synchronous, active high.
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_scan_assembler
  import hkbd_pkg::*;
#(
  parameter int MAX_TEXT = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     report_valid,
  output logic          report_ready,
  input  wire hkbd_in_t report,
  output logic          scan_valid,
  input  wire logic     scan_ready,
  output hkbd_out_t     scan
);

  localparam int IDX_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int LEN_W = $clog2(MAX_TEXT + 1);

  seq_state_t              state, state_next;
  logic [SLOT_W-1:0]       slot, slot_next;
  lane_info_t              lanes [SLOTS];
  lane_info_t              lanes_next [SLOTS];
  lane_info_t              lane_out [SLOTS];
  logic [SLOTS-1:0][7:0]   held, held_next;
  logic [SLOTS-1:0][7:0]   keys;
  logic [LEN_W-1:0]        text_length, text_length_next;
  logic                    overflowed, overflowed_next;
  logic [COUNT_W-1:0]      emit_count, emit_count_next;
  logic [IDX_W-1:0]        rd_idx, rd_idx_next;
  logic                    rd_valid, rd_last;
  logic                    shift;
  logic                    slot_done;
  logic                    last_idx;
  logic                    move;
  logic                    issue_ok;
  logic                    wr_en, rd_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [6:0]              wr_data;
  logic [6:0]              rd_data;
  lane_info_t              cur;

  assign keys  = {report.key_5, report.key_4, report.key_3,
                  report.key_2, report.key_1, report.key_0};
  assign shift = (report.modifiers & SHIFT_MASK) != 8'h00;

  // one lane per key slot
  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    hkbd_lane u_lane (
      .key   (keys[g]),
      .shift (shift),
      .held  (held),
      .info  (lane_out[g])
    );
  end

  hkbd_text_buf #(
    .DEPTH  (MAX_TEXT),
    .ADDR_W (IDX_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // read stage and output register handshake
  assign move     = rd_valid && (!scan_valid || scan_ready);
  assign issue_ok = !rd_valid || move;
  assign last_idx = (LEN_W'(rd_idx) + LEN_W'(1)) == text_length;
  assign cur      = lanes[slot];

  // merge sequencer: applies lane results in slot order
  always_comb begin
    state_next       = state;
    slot_next        = slot;
    lanes_next       = lanes;
    held_next        = held;
    text_length_next = text_length;
    overflowed_next  = overflowed;
    emit_count_next  = emit_count;
    rd_idx_next      = rd_idx;
    wr_en            = 1'b0;
    wr_addr          = IDX_W'(text_length);
    wr_data          = cur.ch;
    rd_en            = 1'b0;
    slot_done        = 1'b0;
    report_ready     = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (report_valid) begin
          if (report.mode) begin
            held_next        = '0;
            text_length_next = '0;
            overflowed_next  = 1'b0;
          end else if (report.report_length >= 7'(REPORT_BYTES)) begin
            held_next       = keys;
            lanes_next      = lane_out;
            slot_next       = '0;
            emit_count_next = '0;
            state_next      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        unique case (cur.kind)
          KIND_ENTER: begin
            if (!overflowed && text_length != '0 &&
                emit_count != COUNT_W'(OUT_LIMIT)) begin
              rd_idx_next = '0;
              state_next  = ST_EMIT;
            end else begin
              text_length_next = '0;
              overflowed_next  = 1'b0;
              slot_done        = 1'b1;
            end
          end
          KIND_BKSP: begin
            if (text_length != '0) text_length_next = text_length - LEN_W'(1);
            slot_done = 1'b1;
          end
          KIND_CHAR: begin
            if (text_length >= LEN_W'(MAX_TEXT)) begin
              overflowed_next = 1'b1;
            end else begin
              wr_en            = 1'b1;
              text_length_next = text_length + LEN_W'(1);
            end
            slot_done = 1'b1;
          end
          KIND_NONE: begin
            slot_done = 1'b1;
          end
          default: begin
            slot_done = 1'b1;
          end
        endcase
      end
      ST_EMIT: begin
        if (issue_ok) begin
          rd_en           = 1'b1;
          emit_count_next = emit_count + COUNT_W'(1);
          if (last_idx || emit_count == COUNT_W'(OUT_LIMIT - 1)) begin
            text_length_next = '0;
            overflowed_next  = 1'b0;
            slot_done        = 1'b1;
          end else begin
            rd_idx_next = rd_idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // step to the next slot or finish the report
    if (slot_done) begin
      if (slot == SLOT_W'(SLOTS - 1)) begin
        state_next = ST_IDLE;
      end else begin
        slot_next  = slot + SLOT_W'(1);
        state_next = ST_SCAN;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      held        <= '0;
      text_length <= '0;
      overflowed  <= 1'b0;
      rd_valid    <= 1'b0;
      scan_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      held        <= held_next;
      text_length <= text_length_next;
      overflowed  <= overflowed_next;
      if (rd_en) begin
        rd_valid <= 1'b1;
      end else if (move) begin
        rd_valid <= 1'b0;
      end
      if (move) begin
        scan_valid <= 1'b1;
      end else if (scan_ready) begin
        scan_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot       <= slot_next;
    lanes      <= lanes_next;
    emit_count <= emit_count_next;
    rd_idx     <= rd_idx_next;
    if (rd_en) rd_last <= last_idx;
    if (move) begin
      scan.scan_char <= rd_data;
      scan.scan_last <= rd_last;
    end
  end

endmodule

`default_nettype wire
